### sv/pra_pkg.sv
package pra_pkg;

    localparam int unsigned SampleWidth = 16;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned AddrWidth   = 5;
    localparam int unsigned DataWidth   = 32;

    // Register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_REQUESTED   = 3'd0,
        REG_DEPTH_16    = 3'd1,
        REG_CHANNELS    = 3'd2,
        REG_HAS_COLOR   = 3'd3,
        REG_HAS_ALPHA   = 3'd4,
        REG_ALPHA_FIRST = 3'd5,
        REG_BKGD_GRAY   = 3'd6,
        REG_UNUSED      = 3'd7
    } reg_index_t;

    // Bit positions in the reduction flag vector
    localparam int unsigned FlagDepth = 0;
    localparam int unsigned FlagGray  = 1;
    localparam int unsigned FlagAlpha = 2;

    typedef logic [2:0] flags_t;
    typedef logic [SampleWidth-1:0] sample_t;

endpackage

### sv/pixel_reducibility_analyzer.sv
// Channel   | Handshake                   | Payload
// pixel     | pixel_valid / pixel_stall   | first_pixel, sample_a..sample_d
// result    | result_valid / result_stall | can_halve_depth, can_make_gray, can_drop_alpha,
//           |                             | none_left
// config    | APB write/read              | seven registers at 4*i, pready tied high
//
// One pixel per cycle while pixel_stall is low.
// An input register feeds the compare logic, whose outcome loads the result register
// and the sticky flags in the same edge, so the next pixel sees the updated flags.
// rst_n clears valids and sticky flags, resets config; flags stay clear till a first pixel.
// A stalled result holds the pipe; pixel_stall rises only when both stages are full.
module pixel_reducibility_analyzer
    import pra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  logic                 first_pixel,
    input  logic [15:0]          sample_a,
    input  logic [15:0]          sample_b,
    input  logic [15:0]          sample_c,
    input  logic [15:0]          sample_d,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 can_halve_depth,
    output logic                 can_make_gray,
    output logic                 can_drop_alpha,
    output logic                 none_left,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready
);

    // configuration
    logic [2:0] requested_reg;
    logic       depth16_reg;
    logic [2:0] channels_reg;
    logic       has_color_reg;
    logic       has_alpha_reg;
    logic       alpha_first_reg;
    logic       bkgd_not_gray_reg;

    // input stage
    logic       in_valid_reg;
    logic       in_first_reg;
    sample_t    in_sample_reg [4];

    // result stage and state
    logic       out_valid_reg;
    flags_t     out_flags_reg;
    flags_t     possible_reg;

    logic       cfg_write;
    reg_index_t cfg_index;
    logic       out_free;
    logic       advance;
    logic       in_take;

    sample_t    smp [4];
    sample_t    full_mask;
    logic [1:0] last_idx;
    logic [1:0] gray_base;
    logic [1:0] alpha_idx;
    logic [3:0] byte_match;
    logic [3:0] lane_used;
    flags_t     load_mask;
    flags_t     flags_in;
    flags_t     flags_next;
    logic       depth_ok;
    logic       gray_ok;
    logic       alpha_ok;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_reg     <= 3'd7;
            depth16_reg       <= 1'b0;
            channels_reg      <= 3'd1;
            has_color_reg     <= 1'b0;
            has_alpha_reg     <= 1'b0;
            alpha_first_reg   <= 1'b0;
            bkgd_not_gray_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_REQUESTED:   requested_reg     <= pwdata[2:0];
                REG_DEPTH_16:    depth16_reg       <= pwdata[0];
                REG_CHANNELS:    channels_reg      <= pwdata[2:0];
                REG_HAS_COLOR:   has_color_reg     <= pwdata[0];
                REG_HAS_ALPHA:   has_alpha_reg     <= pwdata[0];
                REG_ALPHA_FIRST: alpha_first_reg   <= pwdata[0];
                REG_BKGD_GRAY:   bkgd_not_gray_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_REQUESTED:   prdata = {29'd0, requested_reg};
            REG_DEPTH_16:    prdata = {31'd0, depth16_reg};
            REG_CHANNELS:    prdata = {29'd0, channels_reg};
            REG_HAS_COLOR:   prdata = {31'd0, has_color_reg};
            REG_HAS_ALPHA:   prdata = {31'd0, has_alpha_reg};
            REG_ALPHA_FIRST: prdata = {31'd0, alpha_first_reg};
            REG_BKGD_GRAY:   prdata = {31'd0, bkgd_not_gray_reg};
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign out_free    = !out_valid_reg || !result_stall;
    assign advance     = in_valid_reg && out_free;
    assign pixel_stall = in_valid_reg && !out_free;
    assign in_take     = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            possible_reg  <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                possible_reg  <= flags_next;
            end
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_first_reg     <= first_pixel;
            in_sample_reg[0] <= sample_a;
            in_sample_reg[1] <= sample_b;
            in_sample_reg[2] <= sample_c;
            in_sample_reg[3] <= sample_d;
        end
        if (advance)
            out_flags_reg <= flags_next;
    end

    // pixel tests
    always_comb
    begin
        full_mask = depth16_reg ? '1 : sample_t'({ByteWidth{1'b1}});
        for (int i = 0; i < 4; i++)
        begin
            smp[i]        = in_sample_reg[i] & full_mask;
            byte_match[i] = smp[i][15:8] == smp[i][7:0];
        end

        // clamp channel count to 1..4
        if (channels_reg == 3'd0)
            last_idx = 2'd0;
        else if (channels_reg > 3'd4)
            last_idx = 2'd3;
        else
            last_idx = 2'(channels_reg - 3'd1);

        for (int i = 0; i < 4; i++)
            lane_used[i] = 2'(i) <= last_idx;

        load_mask = requested_reg;
        if (!depth16_reg)
            load_mask[FlagDepth] = 1'b0;
        if (!has_color_reg || bkgd_not_gray_reg)
            load_mask[FlagGray] = 1'b0;
        if (!has_alpha_reg)
            load_mask[FlagAlpha] = 1'b0;

        flags_in = in_first_reg ? load_mask : possible_reg;

        depth_ok  = depth16_reg && ((byte_match | ~lane_used) == 4'hF);
        gray_base = alpha_first_reg ? 2'd1 : 2'd0;
        gray_ok   = (smp[gray_base] == smp[gray_base + 2'd1])
                 && (smp[gray_base] == smp[gray_base + 2'd2]);
        alpha_idx = alpha_first_reg ? 2'd0 : last_idx;
        alpha_ok  = smp[alpha_idx] == full_mask;

        flags_next            = flags_in;
        flags_next[FlagDepth] = flags_in[FlagDepth] && depth_ok;
        flags_next[FlagGray]  = flags_in[FlagGray] && gray_ok;
        flags_next[FlagAlpha] = flags_in[FlagAlpha] && alpha_ok;
    end

    assign result_valid    = out_valid_reg;
    assign can_halve_depth = out_flags_reg[FlagDepth];
    assign can_make_gray   = out_flags_reg[FlagGray];
    assign can_drop_alpha  = out_flags_reg[FlagAlpha];
    assign none_left       = out_flags_reg == '0;

endmodule

### sv/pra_checker.sv
module pra_checker
    import pra_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pixel_valid,
    input logic                 pixel_stall,
    input logic                 first_pixel,
    input logic [15:0]          sample_a,
    input logic [15:0]          sample_b,
    input logic [15:0]          sample_c,
    input logic [15:0]          sample_d,
    input logic                 result_valid,
    input logic                 result_stall,
    input logic                 can_halve_depth,
    input logic                 can_make_gray,
    input logic                 can_drop_alpha,
    input logic                 none_left,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [AddrWidth-1:0] paddr,
    input logic [DataWidth-1:0] pwdata,
    input logic [DataWidth-1:0] prdata,
    input logic                 pready
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid
            && $stable({can_halve_depth, can_make_gray, can_drop_alpha, none_left}))
        else $error("stalled result changed");

    a_none_left: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> none_left == !(can_halve_depth || can_make_gray || can_drop_alpha))
        else $error("none_left disagrees with flags");

    // a fresh result follows an earlier pixel transfer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_valid && !pixel_stall, 2))
        else $error("result without a pixel transfer");

    // the pipe holds at most two pixels, so stall needs a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("pixel stall without a stalled result");

endmodule

bind pixel_reducibility_analyzer pra_checker u_pra_checker (.*);

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pra_pkg::*;

    localparam int unsigned TotalPixels   = 750;
    localparam int unsigned IdlePercent   = 15;
    localparam int unsigned DrainCycles   = 4;
    localparam int unsigned WatchdogLimit = 2000;

    // one bit per result field, none_left on top
    typedef struct packed {
        logic none_left;
        logic drop_alpha;
        logic make_gray;
        logic halve_depth;
    } verdict_t;

    typedef struct packed {
        logic [2:0] req;
        logic       d16;
        logic [2:0] chans;
        logic       color;
        logic       alpha;
        logic       afirst;
        logic       bng;
    } setup_t;

    typedef struct packed {
        logic     is_cfg;
        setup_t   setup;
        logic     first;
        sample_t  a;
        sample_t  b;
        sample_t  c;
        sample_t  d;
        logic     typed;
        verdict_t want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 pixel_valid;
    logic                 pixel_stall;
    logic                 first_pixel;
    logic [15:0]          sample_a;
    logic [15:0]          sample_b;
    logic [15:0]          sample_c;
    logic [15:0]          sample_d;
    logic                 result_valid;
    logic                 result_stall;
    logic                 can_halve_depth;
    logic                 can_make_gray;
    logic                 can_drop_alpha;
    logic                 none_left;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [DataWidth-1:0] pwdata;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    setup_t      live_setup;
    flags_t      sticky_flags;
    verdict_t    pending_verdicts [$];
    int unsigned mismatches;
    int unsigned idle_pct;
    row_t        directed_rows [30];

    pixel_reducibility_analyzer uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic row_t cfg_row(logic [2:0] req, logic d16, logic [2:0] chans,
                                     logic color, logic alpha, logic afirst, logic bng);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.setup = '{req: req, d16: d16, chans: chans, color: color, alpha: alpha,
                    afirst: afirst, bng: bng};
        return r;
    endfunction

    function automatic row_t pix_row(logic first, sample_t a, sample_t b, sample_t c,
                                     sample_t d);
        row_t r;
        r = '0;
        r.first = first;
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

    function automatic row_t want_row(logic first, sample_t a, sample_t b, sample_t c,
                                      sample_t d, verdict_t want);
        row_t r;
        r = pix_row(first, a, b, c, d);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    // Apply one pixel to the flag copy and return what the block should report.
    function automatic verdict_t advance_flags(logic first, sample_t a, sample_t b,
                                               sample_t c, sample_t d);
        sample_t     smask;
        sample_t     s [4];
        int unsigned n;
        int unsigned c0;
        int unsigned ai;
        int unsigned i;
        logic        ok;
        flags_t      f;
        verdict_t    v;
        smask = live_setup.d16 ? 16'hFFFF : 16'h00FF;
        s[0] = a & smask;
        s[1] = b & smask;
        s[2] = c & smask;
        s[3] = d & smask;
        n = (live_setup.chans == 0) ? 1 : (live_setup.chans > 4) ? 4 : live_setup.chans;
        if (first)
        begin
            f = live_setup.req;
            if (!live_setup.d16)
                f[FlagDepth] = 1'b0;
            if (!live_setup.color || live_setup.bng)
                f[FlagGray] = 1'b0;
            if (!live_setup.alpha)
                f[FlagAlpha] = 1'b0;
        end
        else
            f = sticky_flags;
        ok = live_setup.d16;
        for (i = 0; i < n; i++)
            if (s[i][15:8] != s[i][7:0])
                ok = 1'b0;
        if (!ok)
            f[FlagDepth] = 1'b0;
        c0 = live_setup.afirst ? 1 : 0;
        if (s[c0] != s[c0 + 1] || s[c0] != s[c0 + 2])
            f[FlagGray] = 1'b0;
        ai = live_setup.afirst ? 0 : n - 1;
        if (s[ai] != smask)
            f[FlagAlpha] = 1'b0;
        sticky_flags = f;
        v.halve_depth = f[FlagDepth];
        v.make_gray = f[FlagGray];
        v.drop_alpha = f[FlagAlpha];
        v.none_left = (f == '0);
        return v;
    endfunction

    task automatic reg_write(reg_index_t idx, logic [DataWidth-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read(reg_index_t idx, output logic [DataWidth-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        val = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setup(setup_t next);
        reg_index_t           idx;
        logic [DataWidth-1:0] val;
        logic [DataWidth-1:0] back;
        int                   i;
        for (i = 0; i < REG_UNUSED; i++)
        begin
            idx = reg_index_t'(i);
            case (idx)
                REG_REQUESTED:   val = DataWidth'(next.req);
                REG_DEPTH_16:    val = DataWidth'(next.d16);
                REG_CHANNELS:    val = DataWidth'(next.chans);
                REG_HAS_COLOR:   val = DataWidth'(next.color);
                REG_HAS_ALPHA:   val = DataWidth'(next.alpha);
                REG_ALPHA_FIRST: val = DataWidth'(next.afirst);
                REG_BKGD_GRAY:   val = DataWidth'(next.bng);
                default:         val = '0;
            endcase
            reg_write(idx, val);
            reg_read(idx, back);
            if (back !== val)
            begin
                mismatches++;
                $display("%0t: register %s read back, expected %0h got %0h",
                         $realtime, idx.name(), val, back);
            end
        end
        live_setup = next;
    endtask

    // Drop valid, wait for every pending result, then let the pipe empty.
    task automatic settle();
        pixel_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic send_pixel(logic first, sample_t a, sample_t b, sample_t c, sample_t d,
                              logic typed, verdict_t want);
        verdict_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        first_pixel <= first;
        sample_a <= a;
        sample_b <= b;
        sample_c <= c;
        sample_d <= d;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        got = advance_flags(first, a, b, c, d);
        pending_verdicts.push_back(typed ? want : got);
    endtask

    task automatic compare_bit(string field, logic want, logic got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0b got %0b", $realtime, field, want, got);
        end
    endtask

    // result side: random stall, check each transfer against the oldest prediction
    initial
    begin
        verdict_t want;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transfer with no pixel pending", $realtime);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    compare_bit("can_halve_depth", want.halve_depth, can_halve_depth);
                    compare_bit("can_make_gray", want.make_gray, can_make_gray);
                    compare_bit("can_drop_alpha", want.drop_alpha, can_drop_alpha);
                    compare_bit("none_left", want.none_left, none_left);
                end
            end
            result_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WatchdogLimit)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned sent;
        int unsigned len;
        int unsigned n;
        int unsigned c0;
        int unsigned ai;
        int unsigned i;
        int unsigned k;
        logic        mark;
        sample_t     s [4];
        setup_t      pick;
        rst_n <= 1'b0;
        pixel_valid <= 1'b0;
        first_pixel <= 1'b0;
        sample_a <= '0;
        sample_b <= '0;
        sample_c <= '0;
        sample_d <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        mismatches = 0;
        idle_pct = IdlePercent;
        sticky_flags = '0;
        live_setup = '{req: 3'd7, d16: 1'b0, chans: 3'd1, color: 1'b0, alpha: 1'b0,
                       afirst: 1'b0, bng: 1'b0};
        directed_rows = '{
            // flags stay clear before any first mark, and reset setup loads nothing
            want_row(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b1000),
            want_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1000),
            // 16-bit RGBA, alpha last: knock the flags out one at a time
            cfg_row(3'd7, 1'b1, 3'd4, 1'b1, 1'b1, 1'b0, 1'b0),
            want_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b0111),
            pix_row(1'b0, 16'h1212, 16'h1212, 16'h1212, 16'hFFFF),
            pix_row(1'b0, 16'h00FF, 16'h00FF, 16'h00FF, 16'hFFFF),
            pix_row(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE),
            pix_row(1'b0, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF),
            pix_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
            // setup change mid image must not reload
            cfg_row(3'd7, 1'b1, 3'd4, 1'b1, 1'b1, 1'b1, 1'b0),
            want_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1000),
            pix_row(1'b1, 16'hFFFF, 16'h3434, 16'h3434, 16'h3434),
            pix_row(1'b0, 16'h0000, 16'h3434, 16'h3434, 16'h3435),
            // colored background forbids gray
            cfg_row(3'd7, 1'b1, 3'd4, 1'b1, 1'b1, 1'b0, 1'b1),
            want_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b0101),
            cfg_row(3'd0, 1'b1, 3'd4, 1'b1, 1'b1, 1'b0, 1'b0),
            want_row(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1000),
            // 8-bit: depth always fails, high bytes ignored
            cfg_row(3'd7, 1'b0, 3'd4, 1'b1, 1'b1, 1'b0, 1'b0),
            pix_row(1'b1, 16'hAB12, 16'hCD12, 16'hEF12, 16'h00FF),
            pix_row(1'b0, 16'h0012, 16'h0012, 16'h0013, 16'h12FF),
            // channel count 0 acts as 1, 7 acts as 4
            cfg_row(3'd7, 1'b1, 3'd0, 1'b0, 1'b1, 1'b0, 1'b0),
            pix_row(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000),
            cfg_row(3'd7, 1'b1, 3'd7, 1'b1, 1'b1, 1'b0, 1'b0),
            pix_row(1'b1, 16'h5555, 16'h5555, 16'h5555, 16'hFFFF),
            pix_row(1'b0, 16'h5555, 16'h5555, 16'h5555, 16'h0000),
            cfg_row(3'd7, 1'b1, 3'd2, 1'b0, 1'b1, 1'b1, 1'b0),
            pix_row(1'b1, 16'hFFFF, 16'h8080, 16'h1234, 16'h0000),
            cfg_row(3'd7, 1'b1, 3'd3, 1'b1, 1'b0, 1'b0, 1'b0),
            pix_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
            pix_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000)
        };
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
            begin
                settle();
                apply_setup(directed_rows[r].setup);
            end
            else
            begin
                send_pixel(directed_rows[r].first, directed_rows[r].a, directed_rows[r].b,
                           directed_rows[r].c, directed_rows[r].d, directed_rows[r].typed,
                           directed_rows[r].want);
                sent++;
            end
        end

        // random images: mostly well-formed pixels that keep flags alive for a while
        while (sent < TotalPixels)
        begin
            idle_pct = (sent >= 250 && sent < 400) ? 0 : IdlePercent;
            // keep the setup during the stretch without idling
            if (idle_pct != 0 && $urandom_range(99) < 75)
            begin
                settle();
                pick.req = ($urandom_range(99) < 60) ? 3'd7 : 3'($urandom_range(7));
                pick.d16 = 1'($urandom_range(1));
                pick.chans = ($urandom_range(99) < 80) ? 3'($urandom_range(1, 4))
                                                       : 3'($urandom_range(7));
                pick.color = 1'($urandom_range(1));
                pick.alpha = 1'($urandom_range(1));
                pick.afirst = 1'($urandom_range(1));
                pick.bng = ($urandom_range(99) < 20);
                apply_setup(pick);
            end
            len = $urandom_range(1, 40);
            mark = ($urandom_range(99) < 90);
            for (k = 0; k < len && sent < TotalPixels; k++)
            begin
                for (i = 0; i < 4; i++)
                    s[i] = 16'($urandom);
                if ($urandom_range(99) < 85)
                begin
                    n = (live_setup.chans == 0) ? 1 :
                        (live_setup.chans > 4) ? 4 : live_setup.chans;
                    c0 = live_setup.afirst ? 1 : 0;
                    ai = live_setup.afirst ? 0 : n - 1;
                    if ($urandom_range(99) < 96)
                        for (i = 0; i < 4; i++)
                            s[i][15:8] = s[i][7:0];
                    if ($urandom_range(99) < 96)
                    begin
                        s[c0 + 1] = s[c0];
                        s[c0 + 2] = s[c0];
                    end
                    if ($urandom_range(99) < 96)
                    begin
                        if (live_setup.d16)
                            s[ai] = 16'hFFFF;
                        else
                            s[ai][7:0] = 8'hFF;
                    end
                end
                send_pixel((k == 0 && mark) || ($urandom_range(99) < 2),
                           s[0], s[1], s[2], s[3], 1'b0, '0);
                sent++;
            end
        end

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
sv/pra_pkg.sv
sv/pixel_reducibility_analyzer.sv
sv/pra_checker.sv
dv/tb.sv
